>>> sv/opr_pkg.sv
package opr_pkg;

  // Fixed field widths
  localparam int FAULT_W = 11;
  localparam int CFG_W   = 5;

  // Defaults for the top level parameters
  localparam int MAX_REFS_DEF   = 1024;
  localparam int MAX_FRAMES_DEF = 16;
  localparam int PAGE_BITS_DEF  = 10;

  // Frame count after reset
  localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 5'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    S_LOAD,
    S_FETCH,
    S_CHECK,
    S_SCAN,
    S_DONE
  } state_t;

  // Sequencer to frame bank
  typedef struct packed {
    logic fill;       // write page into the next empty frame
    logic evict;      // overwrite the chosen victim frame
    logic scan_init;  // arm the not-yet-seen mask for a look-ahead scan
    logic scan_cmp;   // read data of the scan is valid this cycle
  } frame_ctrl_t;

  // Frame bank to sequencer
  typedef struct packed {
    logic hit;        // page is held in a filled frame
    logic one_left;   // exactly one frame still without a later use
  } frame_status_t;

endpackage

>>> sv/opr_ref_mem.sv
module opr_ref_mem #(
  parameter int DEPTH  = opr_pkg::MAX_REFS_DEF,
  parameter int WIDTH  = opr_pkg::PAGE_BITS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Single write port, single registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/opr_frames.sv
module opr_frames #(
  parameter int MAX_FRAMES = opr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = opr_pkg::PAGE_BITS_DEF,
  parameter int FCNT_W     = $clog2(MAX_FRAMES + 1)
) (
  input  logic                  clk,
  input  opr_pkg::frame_ctrl_t  ctrl,
  input  logic [FCNT_W-1:0]     nf,
  input  logic [FCNT_W-1:0]     filled,
  input  logic [PAGE_BITS-1:0]  rd_page,
  input  logic [PAGE_BITS-1:0]  wr_page,
  output opr_pkg::frame_status_t status
);

  localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  logic [PAGE_BITS-1:0]  page_r [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] unseen_r;
  logic [MAX_FRAMES-1:0] unseen_nxt;
  logic [MAX_FRAMES-1:0] match;
  logic [MAX_FRAMES-1:0] active;
  logic [FIDX_W-1:0]     victim;
  logic                  hit;

  // Per-frame comparators: hit check and look-ahead match
  always_comb begin
    hit = 1'b0;
    for (int j = 0; j < MAX_FRAMES; j++) begin
      active[j] = FCNT_W'(j) < nf;
      match[j]  = ctrl.scan_cmp && unseen_r[j] && (page_r[j] == rd_page);
      if ((FCNT_W'(j) < filled) && (page_r[j] == rd_page)) begin
        hit = 1'b1;
      end
    end
    unseen_nxt = unseen_r & ~match;
  end

  // Lowest frame still without a later use
  always_comb begin
    victim = '0;
    for (int j = MAX_FRAMES - 1; j >= 0; j--) begin
      if (unseen_nxt[j]) begin
        victim = FIDX_W'(j);
      end
    end
  end

  always_comb begin
    status.hit      = hit;
    status.one_left = (unseen_nxt != '0) &&
                      ((unseen_nxt & (unseen_nxt - 1'b1)) == '0);
  end

  // Frame contents and scan mask
  always_ff @(posedge clk) begin
    if (ctrl.scan_init) begin
      unseen_r <= active;
    end else begin
      unseen_r <= unseen_nxt;
    end
    if (ctrl.fill) begin
      page_r[filled[FIDX_W-1:0]] <= wr_page;
    end
    if (ctrl.evict) begin
      page_r[victim] <= wr_page;
    end
  end

endmodule

>>> sv/optimal_page_replacement_faults_core.sv
// Optimal (Belady) page replacement fault counter.
//
// Input channel (in_valid / in_stall): one page number per transaction. A
// transaction with in_last_ref high closes the reference string and starts the
// simulation. References past MAX_REFS are dropped and flagged in the result.
// Loading takes one transaction per cycle; in_stall is high while simulating.
//
// Simulation: for every stored reference one store read (S_FETCH, then the
// check in S_CHECK); a miss with all frames full adds a forward scan of the
// store, one entry per cycle, that stops once only one frame remains without
// a later use or the string is exhausted. All reads share the single store
// port.
//
// Result channel (out_valid / out_stall): one transaction per string with the
// fault count and the overflow flag. The result sits in an output register, so
// a new string loads while the result waits; a further result waits in the
// done state until the register is free.
//
// Configuration: cfg_wr_en writes the frame count (0 acts as 1, values above
// MAX_FRAMES saturate). Reset leaves the block empty with a frame count of 3.
module optimal_page_replacement_faults_core #(
  parameter int MAX_REFS   = opr_pkg::MAX_REFS_DEF,
  parameter int MAX_FRAMES = opr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = opr_pkg::PAGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [PAGE_BITS-1:0]        in_page_number,
  input  logic                        in_last_ref,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [opr_pkg::FAULT_W-1:0] out_fault_count,
  output logic                        out_overflowed,
  input  logic                        cfg_wr_en,
  input  logic [opr_pkg::CFG_W-1:0]   cfg_wr_data
);

  localparam int ADDR_W  = $clog2(MAX_REFS);
  localparam int CNT_W   = $clog2(MAX_REFS + 1);
  localparam int FCNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int FAULT_W = opr_pkg::FAULT_W;

  opr_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]         total_r, total_nxt;
  logic [CNT_W-1:0]         i_r, i_nxt;
  logic [CNT_W-1:0]         k_r, k_nxt;
  logic                     pend_r, pend_nxt;
  logic [FAULT_W-1:0]       fault_r, fault_nxt;
  logic                     drop_r, drop_nxt;
  logic [FCNT_W-1:0]        filled_r, filled_nxt;
  logic [PAGE_BITS-1:0]     cur_page_r, cur_page_nxt;
  logic [opr_pkg::CFG_W-1:0] frame_count_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [FAULT_W-1:0]       out_fault_r, out_fault_nxt;
  logic                     out_drop_r, out_drop_nxt;

  logic                     mem_wr_en;
  logic [ADDR_W-1:0]        mem_wr_addr;
  logic                     mem_rd_en;
  logic [ADDR_W-1:0]        mem_rd_addr;
  logic [PAGE_BITS-1:0]     mem_rd_data;

  opr_pkg::frame_ctrl_t     fctrl;
  opr_pkg::frame_status_t   fstat;
  logic [FCNT_W-1:0]        nf;
  logic [PAGE_BITS-1:0]     wr_page;
  logic [CNT_W-1:0]         i_inc;
  logic                     in_accept;
  logic                     issue;

  // Reference string store
  opr_ref_mem #(
    .DEPTH (MAX_REFS),
    .WIDTH (PAGE_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (in_page_number),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Frame bank with comparators and victim choice
  opr_frames #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_frames (
    .clk     (clk),
    .ctrl    (fctrl),
    .nf      (nf),
    .filled  (filled_r),
    .rd_page (mem_rd_data),
    .wr_page (wr_page),
    .status  (fstat)
  );

  // Frames in use, clamped to 1..MAX_FRAMES
  always_comb begin
    if (frame_count_r == '0) begin
      nf = FCNT_W'(1);
    end else if (32'(frame_count_r) > 32'(MAX_FRAMES)) begin
      nf = FCNT_W'(MAX_FRAMES);
    end else begin
      nf = FCNT_W'(frame_count_r);
    end
  end

  assign in_stall        = (state_r != opr_pkg::S_LOAD);
  assign in_accept       = in_valid && !in_stall;
  assign i_inc           = i_r + 1'b1;
  assign issue           = k_r < total_r;
  assign wr_page         = fctrl.fill ? mem_rd_data : cur_page_r;
  assign out_valid       = out_valid_r;
  assign out_fault_count = out_fault_r;
  assign out_overflowed  = out_drop_r;

  // Sequencer: next state and controls
  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    pend_nxt      = pend_r;
    fault_nxt     = fault_r;
    drop_nxt      = drop_r;
    filled_nxt    = filled_r;
    cur_page_nxt  = cur_page_r;
    out_valid_nxt = out_valid_r;
    out_fault_nxt = out_fault_r;
    out_drop_nxt  = out_drop_r;
    fctrl         = '0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = total_r[ADDR_W-1:0];
    mem_rd_en     = 1'b0;
    mem_rd_addr   = i_r[ADDR_W-1:0];

    // result taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      opr_pkg::S_LOAD: begin
        if (in_accept) begin
          if (total_r < CNT_W'(MAX_REFS)) begin
            mem_wr_en = 1'b1;
            total_nxt = total_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last_ref) begin
            i_nxt      = '0;
            fault_nxt  = '0;
            filled_nxt = '0;
            state_nxt  = opr_pkg::S_FETCH;
          end
        end
      end

      opr_pkg::S_FETCH: begin
        mem_rd_en = 1'b1;
        state_nxt = opr_pkg::S_CHECK;
      end

      opr_pkg::S_CHECK: begin
        if (fstat.hit) begin
          i_nxt     = i_inc;
          state_nxt = (i_inc == total_r) ? opr_pkg::S_DONE : opr_pkg::S_FETCH;
        end else begin
          fault_nxt = fault_r + 1'b1;
          if (filled_r < nf) begin
            fctrl.fill = 1'b1;
            filled_nxt = filled_r + 1'b1;
            i_nxt      = i_inc;
            state_nxt  = (i_inc == total_r) ? opr_pkg::S_DONE : opr_pkg::S_FETCH;
          end else begin
            // all frames full: look ahead for the victim
            cur_page_nxt    = mem_rd_data;
            fctrl.scan_init = 1'b1;
            k_nxt           = i_inc;
            pend_nxt        = 1'b0;
            state_nxt       = opr_pkg::S_SCAN;
          end
        end
      end

      opr_pkg::S_SCAN: begin
        fctrl.scan_cmp = pend_r;
        mem_rd_addr    = k_r[ADDR_W-1:0];
        if (issue) begin
          mem_rd_en = 1'b1;
          k_nxt     = k_r + 1'b1;
        end
        pend_nxt = issue;
        // stop when one candidate is left or the string is exhausted
        if (fstat.one_left || !issue) begin
          fctrl.evict = 1'b1;
          i_nxt       = i_inc;
          state_nxt   = (i_inc == total_r) ? opr_pkg::S_DONE : opr_pkg::S_FETCH;
        end
      end

      opr_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_fault_nxt = fault_r;
          out_drop_nxt  = drop_r;
          total_nxt     = '0;
          drop_nxt      = 1'b0;
          state_nxt     = opr_pkg::S_LOAD;
        end
      end

      default: begin
        state_nxt = opr_pkg::S_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= opr_pkg::S_LOAD;
      total_r       <= '0;
      drop_r        <= 1'b0;
      fault_r       <= '0;
      filled_r      <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      frame_count_r <= opr_pkg::FRAME_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      drop_r      <= drop_nxt;
      fault_r     <= fault_nxt;
      filled_r    <= filled_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        frame_count_r <= cfg_wr_data;
      end
    end
  end

  // Payload and position registers
  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    k_r         <= k_nxt;
    cur_page_r  <= cur_page_nxt;
    out_fault_r <= out_fault_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  // Checks
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) <= 32'(MAX_REFS))
    else $error("reference count beyond store depth");

  a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == opr_pkg::S_CHECK || state_r == opr_pkg::S_SCAN) |-> filled_r <= nf)
    else $error("more frames filled than in use");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    fctrl.evict |-> (filled_r == nf && state_r == opr_pkg::S_SCAN))
    else $error("eviction with an empty frame left");

  a_faults_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == opr_pkg::S_DONE |-> 32'(fault_r) <= 32'(total_r))
    else $error("more faults than references");

endmodule

>>> tb/sv/tb_optimal_page_replacement_faults_core.sv
module tb_optimal_page_replacement_faults_core;

  localparam int PAGE_BITS  = opr_pkg::PAGE_BITS_DEF;
  localparam int MAX_REFS   = opr_pkg::MAX_REFS_DEF;
  localparam int MAX_FRAMES = opr_pkg::MAX_FRAMES_DEF;
  localparam int FAULT_W    = opr_pkg::FAULT_W;
  localparam int CFG_W      = opr_pkg::CFG_W;
  localparam int SETTLE     = 16;      // quiet cycles before a register write
  localparam int HANG_LIMIT = 300000;  // cycles without any transaction
  localparam int PHASE_REFS = 120;     // random references per frame setting

  // One expected result transaction
  typedef struct {
    logic [FAULT_W-1:0] fault_cnt;
    logic               ovf;
  } fault_result_t;

  // One row of the opening sequence: reps copies of a page, last flag on the
  // final copy; typed rows carry their result, the rest go to the predictor
  typedef struct packed {
    logic [10:0]          reps;
    logic [PAGE_BITS-1:0] page;
    logic                 last;
    logic                 typed;
    logic [FAULT_W-1:0]   fault_cnt;
    logic                 ovf;
  } ref_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [PAGE_BITS-1:0] in_page_number;
  logic                 in_last_ref;
  logic                 out_valid;
  logic                 out_stall;
  logic [FAULT_W-1:0]   out_fault_count;
  logic                 out_overflowed;
  logic                 cfg_wr_en;
  logic [CFG_W-1:0]     cfg_wr_data;

  // Predictor state
  logic [PAGE_BITS-1:0] ref_string[$];
  logic                 refs_dropped;
  logic [CFG_W-1:0]     frame_setting;
  fault_result_t        expected_results[$];

  int  errors;
  int  quiet_cycles;
  bit  steady;

  ref_row_t opening_refs [25] = '{
    '{11'd1,    10'd0,    1'b1, 1'b1, 11'd1, 1'b0},  // lowest page, lone reference
    '{11'd2,    10'd1023, 1'b0, 1'b0, 11'd0, 1'b0},
    '{11'd1,    10'd1023, 1'b1, 1'b1, 11'd1, 1'b0},  // highest page, repeated
    '{11'd1,    10'd1,    1'b0, 1'b0, 11'd0, 1'b0},  // textbook string, three frames
    '{11'd1,    10'd2,    1'b0, 1'b0, 11'd0, 1'b0},
    '{11'd1,    10'd3,    1'b0, 1'b0, 11'd0, 1'b0},
    '{11'd1,    10'd4,    1'b0, 1'b0, 11'd0, 1'b0},
    '{11'd1,    10'd1,    1'b0, 1'b0, 11'd0, 1'b0},
    '{11'd1,    10'd2,    1'b0, 1'b0, 11'd0, 1'b0},
    '{11'd1,    10'd5,    1'b0, 1'b0, 11'd0, 1'b0},
    '{11'd1,    10'd1,    1'b0, 1'b0, 11'd0, 1'b0},
    '{11'd1,    10'd2,    1'b0, 1'b0, 11'd0, 1'b0},
    '{11'd1,    10'd3,    1'b0, 1'b0, 11'd0, 1'b0},
    '{11'd1,    10'd4,    1'b0, 1'b0, 11'd0, 1'b0},
    '{11'd1,    10'd5,    1'b1, 1'b1, 11'd7, 1'b0},
    '{11'd1024, 10'd5,    1'b0, 1'b0, 11'd0, 1'b0},  // fills the store
    '{11'd1,    10'd9,    1'b1, 1'b1, 11'd1, 1'b1},  // last reference dropped
    '{11'd1,    10'd3,    1'b1, 1'b1, 11'd1, 1'b0},  // drop flag cleared
    '{11'd1023, 10'd7,    1'b0, 1'b0, 11'd0, 1'b0},  // store exactly full
    '{11'd1,    10'd8,    1'b1, 1'b1, 11'd2, 1'b0},
    '{11'd1,    10'd512,  1'b0, 1'b0, 11'd0, 1'b0},  // tie between unused pages
    '{11'd1,    10'd0,    1'b0, 1'b0, 11'd0, 1'b0},
    '{11'd1,    10'd1023, 1'b0, 1'b0, 11'd0, 1'b0},
    '{11'd1,    10'd256,  1'b0, 1'b0, 11'd0, 1'b0},
    '{11'd1,    10'd512,  1'b1, 1'b0, 11'd0, 1'b0}
  };

  optimal_page_replacement_faults_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_page_number  (in_page_number),
    .in_last_ref     (in_last_ref),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_fault_count (out_fault_count),
    .out_overflowed  (out_overflowed),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // Random idle cycle, roughly a quarter of the time outside steady phases
  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 24);
  endfunction

  // Belady replacement over the held reference string
  function automatic logic [FAULT_W-1:0] optimal_faults();
    int                   nf;
    int                   filled;
    int                   faults;
    int                   victim;
    int                   far;
    int                   nu;
    bit                   hit;
    logic [PAGE_BITS-1:0] held [MAX_FRAMES];
    nf = (frame_setting == 0) ? 1 :
         (frame_setting > MAX_FRAMES) ? MAX_FRAMES : int'(frame_setting);
    filled = 0;
    faults = 0;
    foreach (ref_string[i]) begin
      hit = 1'b0;
      for (int j = 0; j < filled; j++)
        if (held[j] == ref_string[i]) hit = 1'b1;
      if (!hit) begin
        faults++;
        if (filled < nf) begin
          held[filled] = ref_string[i];
          filled++;
        end else begin
          victim = 0;
          far    = 0;
          for (int j = 0; j < nf; j++) begin
            // next use of this frame's page, end of string if none
            nu = ref_string.size();
            for (int k = i + 1; k < ref_string.size(); k++) begin
              if (ref_string[k] == held[j]) begin
                nu = k;
                break;
              end
            end
            if (j == 0 || nu > far) begin
              far    = nu;
              victim = j;
            end
          end
          held[victim] = ref_string[i];
        end
      end
    end
    return faults[FAULT_W-1:0];
  endfunction

  // Send one reference and book its result once the transaction is taken
  task automatic drive_ref(input logic [PAGE_BITS-1:0] page, input logic last,
                           input bit typed, input logic [FAULT_W-1:0] typed_fc,
                           input logic typed_ovf);
    fault_result_t res;
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_page_number <= page;
    in_last_ref    <= last;
    do @(posedge clk); while (in_stall);
    if (ref_string.size() < MAX_REFS) ref_string.push_back(page);
    else refs_dropped = 1'b1;
    if (last) begin
      res.fault_cnt = typed ? typed_fc : optimal_faults();
      res.ovf       = typed ? typed_ovf : refs_dropped;
      expected_results.push_back(res);
      ref_string.delete();
      refs_dropped = 1'b0;
    end
  endtask

  // Drain, let the block settle, then write the frame count
  task automatic set_frame_count(input logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en     <= 1'b1;
    cfg_wr_data   <= val;
    frame_setting  = val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Result side: check each transaction, randomise stall, watch for hangs
  always @(posedge clk) begin
    fault_result_t exp_res;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: fault_count %0d overflowed %0d",
                 out_fault_count, out_overflowed);
          errors++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_fault_count !== exp_res.fault_cnt) begin
            $error("fault_count: expected %0d, actual %0d",
                   exp_res.fault_cnt, out_fault_count);
            errors++;
          end
          if (out_overflowed !== exp_res.ovf) begin
            $error("overflowed: expected %0d, actual %0d",
                   exp_res.ovf, out_overflowed);
            errors++;
          end
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
      out_stall <= take_break();
    end
  end

  // Stimulus
  initial begin
    logic [PAGE_BITS-1:0] pool [24];
    logic [CFG_W-1:0]     frame_plan [7];
    int                   len;
    int                   pool_n;
    int                   sent;
    bit                   wide;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_page_number = '0;
    in_last_ref    = 1'b0;
    out_stall      = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    frame_setting  = opr_pkg::FRAME_COUNT_RST;
    refs_dropped   = 1'b0;
    errors         = 0;
    quiet_cycles   = 0;
    steady         = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening sequence on the reset frame count
    foreach (opening_refs[r])
      for (int k = 0; k < opening_refs[r].reps; k++)
        drive_ref(opening_refs[r].page,
                  opening_refs[r].last && (k == opening_refs[r].reps - 1),
                  opening_refs[r].typed, opening_refs[r].fault_cnt,
                  opening_refs[r].ovf);

    // Zero acts as one frame, above sixteen saturates
    frame_plan = '{5'd0, 5'd1, 5'd16, 5'd31,
                   5'($urandom_range(2, 15)), 5'($urandom_range(17, 30)),
                   5'($urandom_range(31))};
    foreach (frame_plan[p]) begin
      set_frame_count(frame_plan[p]);
      steady = (p == 2);
      // one frame with two alternating pages: a fault on every reference
      if (p == 1)
        for (int k = 0; k < MAX_REFS; k++)
          drive_ref(PAGE_BITS'(k % 2), k == MAX_REFS - 1, 1'b0, '0, 1'b0);
      sent = 0;
      while (sent < PHASE_REFS) begin
        // short strings drawn mostly from a small pool, so pages recur
        len    = ($urandom_range(9) == 0) ? $urandom_range(20, 60)
                                          : $urandom_range(1, 14);
        pool_n = $urandom_range(1, 24);
        wide   = ($urandom_range(7) == 0);
        foreach (pool[i]) pool[i] = PAGE_BITS'($urandom_range(1023));
        for (int k = 0; k < len; k++)
          drive_ref(wide ? PAGE_BITS'($urandom_range(1023))
                         : pool[$urandom_range(pool_n - 1)],
                    k == len - 1, 1'b0, '0, 1'b0);
        sent += len;
      end
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
